@@ src/assert_macros.svh @@
// Assertion macros shared by the scaler modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define BSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define BSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bsr_pkg.sv @@
// Types and constants of the bilinear RGB565 scaler
`timescale 1ns / 1ps
`default_nettype none
package bsr_pkg;

  localparam int WORD_W    = 32;
  localparam int SIZE_W    = 9;
  localparam int COORD_W   = 8;
  localparam int CHAN_N    = 3;
  localparam int CHAN_BITS = 8;
  localparam int BITS_W    = 6;
  localparam int ENTRY_W   = CHAN_N * CHAN_BITS;
  localparam int RGB_W     = 16;
  // Dividend (2x+1)*s*128: 9 + 9 + 7 bits
  localparam int PROD_W    = 2 * SIZE_W;
  localparam int NUM_W     = PROD_W + 7;
  localparam int POS_W     = 17;
  localparam int WGT_W     = 11;
  localparam int TOP_W     = 20;
  localparam int ACC_W     = 30;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int FETCH_LAST = 4;
  localparam int HALF_Q8   = 128;
  localparam int ONE_Q8    = 256;
  localparam int ROUND_Q16 = 32768;
  localparam int CAP_Q16   = 255 * 65536;

  localparam logic [WORD_W-1:0] RESET_RED_MASK   = 32'h00FF_0000;
  localparam logic [WORD_W-1:0] RESET_GREEN_MASK = 32'h0000_FF00;
  localparam logic [WORD_W-1:0] RESET_BLUE_MASK  = 32'h0000_00FF;
  localparam logic [SIZE_W-1:0] RESET_SRC_SIZE   = 9'd256;
  localparam logic [SIZE_W-1:0] RESET_DST_SIZE   = 9'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RED_MASK   = 3'd0,
    CFG_GREEN_MASK = 3'd1,
    CFG_BLUE_MASK  = 3'd2,
    CFG_SRC_WIDTH  = 3'd3,
    CFG_SRC_HEIGHT = 3'd4,
    CFG_DST_WIDTH  = 3'd5,
    CFG_DST_HEIGHT = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_COUNT,
    ST_STORE,
    ST_MUL,
    ST_DIV,
    ST_POST,
    ST_FETCH,
    ST_HORZ,
    ST_VERT,
    ST_DONE
  } ctl_state_e;

  typedef struct packed {
    logic       latch_in;
    logic       aln_step;
    logic       cnt_step;
    logic       store;
    logic       mul_load;
    logic       div_step;
    logic       post;
    logic       axis;
    logic       rd;
    logic [1:0] rd_slot;
    logic       cap;
    logic [1:0] cap_slot;
    logic       h_step;
    logic       v_step;
    logic [1:0] chan;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic aln_done;
    logic cnt_done;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

@@ src/bsr_if.sv @@
// Input and output stream interfaces of the scaler
`timescale 1ns / 1ps
`default_nettype none
interface bsr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [bsr_pkg::WORD_W-1:0]  pixel_word;
  logic [bsr_pkg::COORD_W-1:0] col;
  logic [bsr_pkg::COORD_W-1:0] row;
  modport source (output valid, op, pixel_word, col, row, input ready);
  modport sink   (input valid, op, pixel_word, col, row, output ready);
endinterface

interface bsr_out_if;
  logic                      valid;
  logic                      ready;
  logic [bsr_pkg::RGB_W-1:0] rgb565;
  modport source (output valid, rgb565, input ready);
  modport sink   (input valid, rgb565, output ready);
endinterface
`default_nettype wire

@@ src/bsr_ctrl.sv @@
// Controller state machine of the scaler
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bsr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bsr_pkg::sts_t sts_i,
  output bsr_pkg::cmd_t cmd_o
);
  import bsr_pkg::*;

  ctl_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             axis_q, axis_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    axis_d     = axis_q;
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    cmd_o.rd_slot  = cnt_q[1:0];
    cmd_o.cap_slot = 2'(cnt_q - 5'd1);
    cmd_o.chan     = cnt_q[1:0];
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          axis_d = 1'b0;
          state_d = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        // a read item skips the mask walk
        if (sts_i.op == OP_READ) begin
          state_d = ST_MUL;
        end else if (sts_i.aln_done) begin
          state_d = ST_COUNT;
        end else begin
          cmd_o.aln_step = 1'b1;
        end
      end
      ST_COUNT: begin
        if (sts_i.cnt_done) begin
          state_d = ST_STORE;
        end else begin
          cmd_o.cnt_step = 1'b1;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d = ST_IDLE;
      end
      ST_MUL: begin
        cmd_o.mul_load = 1'b1;
        cnt_d = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        cmd_o.post = 1'b1;
        cnt_d = '0;
        if (axis_q) begin
          state_d = ST_FETCH;
        end else begin
          axis_d = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_FETCH: begin
        // issue four reads, capture each in the cycle after its read
        cmd_o.rd  = (cnt_q != CNT_W'(FETCH_LAST));
        cmd_o.cap = (cnt_q != '0);
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == CNT_W'(FETCH_LAST)) begin
          cnt_d = '0;
          state_d = ST_HORZ;
        end
      end
      ST_HORZ: begin
        cmd_o.h_step = 1'b1;
        state_d = ST_VERT;
      end
      ST_VERT: begin
        cmd_o.v_step = 1'b1;
        if (cnt_q == CNT_W'(CHAN_N - 1)) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 5'd1;
          state_d = ST_HORZ;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `BSR_ASSERT_IMP(a_div_count, state_q == ST_DIV, cnt_q < CNT_W'(NUM_W), "divider overrun")
  `BSR_ASSERT_IMP(a_chan_range, state_q == ST_HORZ || state_q == ST_VERT,
                  cnt_q < CNT_W'(CHAN_N), "channel index out of range")
  `BSR_ASSERT_NXT(a_read_path, state_q == ST_POST && axis_q, state_q == ST_FETCH,
                  "fetch must follow the second axis")

endmodule
`default_nettype wire

@@ src/bsr_dpath.sv @@
// Datapath of the scaler: config, channel extraction, divider, frame store, filter
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bsr_dpath #(
  parameter int MAX_SRC_W = 256,
  parameter int MAX_SRC_H = 256,
  parameter int MAX_DST_W = 256,
  parameter int MAX_DST_H = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bsr_pkg::cmd_t                   cmd_i,
  output bsr_pkg::sts_t                   sts_o,
  input  logic                            cfg_we_i,
  input  logic [bsr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bsr_pkg::WORD_W-1:0]      cfg_wdata_i,
  input  logic                            in_op_i,
  input  logic [bsr_pkg::WORD_W-1:0]      in_pixel_word_i,
  input  logic [bsr_pkg::COORD_W-1:0]     in_col_i,
  input  logic [bsr_pkg::COORD_W-1:0]     in_row_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bsr_pkg::RGB_W-1:0]       out_rgb565_o
);
  import bsr_pkg::*;

  localparam int DEPTH = MAX_SRC_W * MAX_SRC_H;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [CHAN_BITS-1:0] chan8(input logic [WORD_W-1:0] v,
                                                input logic [BITS_W-1:0] n);
    logic [WORD_W-1:0] t;
    if (n == BITS_W'(CHAN_BITS)) t = v;
    else if (n < BITS_W'(CHAN_BITS)) t = v << (BITS_W'(CHAN_BITS) - n);
    else t = v >> (n - BITS_W'(CHAN_BITS));
    return t[CHAN_BITS-1:0];
  endfunction

  function automatic logic [CHAN_BITS-1:0] pick(input logic [ENTRY_W-1:0] e,
                                               input logic [1:0] c);
    logic [CHAN_BITS-1:0] b;
    case (c)
      2'd0:    b = e[23:16];
      2'd1:    b = e[15:8];
      default: b = e[7:0];
    endcase
    return b;
  endfunction

  // configuration
  logic [WORD_W-1:0] mask_q [CHAN_N];
  logic [SIZE_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q[0] <= RESET_RED_MASK;
      mask_q[1] <= RESET_GREEN_MASK;
      mask_q[2] <= RESET_BLUE_MASK;
      src_w_q   <= RESET_SRC_SIZE;
      src_h_q   <= RESET_SRC_SIZE;
      dst_w_q   <= RESET_DST_SIZE;
      dst_h_q   <= RESET_DST_SIZE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RED_MASK:   mask_q[0] <= cfg_wdata_i;
        CFG_GREEN_MASK: mask_q[1] <= cfg_wdata_i;
        CFG_BLUE_MASK:  mask_q[2] <= cfg_wdata_i;
        CFG_SRC_WIDTH:  src_w_q   <= cfg_wdata_i[SIZE_W-1:0];
        CFG_SRC_HEIGHT: src_h_q   <= cfg_wdata_i[SIZE_W-1:0];
        CFG_DST_WIDTH:  dst_w_q   <= cfg_wdata_i[SIZE_W-1:0];
        CFG_DST_HEIGHT: dst_h_q   <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [SIZE_W-1:0] sw, sh, dw, dh;
  always_comb begin
    sw = (src_w_q < 9'd2) ? 9'd2 : ((32'(src_w_q) > MAX_SRC_W) ? SIZE_W'(MAX_SRC_W) : src_w_q);
    sh = (src_h_q < 9'd2) ? 9'd2 : ((32'(src_h_q) > MAX_SRC_H) ? SIZE_W'(MAX_SRC_H) : src_h_q);
    dw = (dst_w_q == '0) ? 9'd1 : ((32'(dst_w_q) > MAX_DST_W) ? SIZE_W'(MAX_DST_W) : dst_w_q);
    dh = (dst_h_q == '0) ? 9'd1 : ((32'(dst_h_q) > MAX_DST_H) ? SIZE_W'(MAX_DST_H) : dst_h_q);
  end

  // item registers and extraction lanes
  logic               op_q;
  logic [COORD_W-1:0] col_q, row_q;
  logic [WORD_W-1:0]  m_q [CHAN_N];
  logic [WORD_W-1:0]  v_q [CHAN_N];
  logic [BITS_W-1:0]  bits_q [CHAN_N];

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q  <= in_op_i;
      col_q <= in_col_i;
      row_q <= in_row_i;
    end
    for (int c = 0; c < CHAN_N; c++) begin
      if (cmd_i.latch_in) begin
        m_q[c]    <= mask_q[c];
        v_q[c]    <= in_pixel_word_i & mask_q[c];
        bits_q[c] <= '0;
      end else if (cmd_i.aln_step) begin
        // walk down to the lowest set mask bit
        if (m_q[c] != '0 && !m_q[c][0]) begin
          m_q[c] <= m_q[c] >> 1;
          v_q[c] <= v_q[c] >> 1;
        end
      end else if (cmd_i.cnt_step) begin
        if (m_q[c][0]) begin
          m_q[c]    <= m_q[c] >> 1;
          bits_q[c] <= bits_q[c] + 6'd1;
        end
      end
    end
  end

  always_comb begin
    sts_o.op       = op_q;
    sts_o.aln_done = 1'b1;
    sts_o.cnt_done = 1'b1;
    for (int c = 0; c < CHAN_N; c++) begin
      if (m_q[c] != '0 && !m_q[c][0]) sts_o.aln_done = 1'b0;
      if (m_q[c][0]) sts_o.cnt_done = 1'b0;
    end
    sts_o.out_busy = out_valid_o && !out_ready_i;
  end

  // axis mapping and bit-serial divider
  logic                 axis_sel;
  logic [SIZE_W-1:0]    s_sel, d_sel, d_m1;
  logic [COORD_W-1:0]   c_sel, x_cl;
  logic [PROD_W-1:0]    prod;
  logic [NUM_W-1:0]     num_q;
  logic [SIZE_W-1:0]    den_q, rem_q;
  logic [SIZE_W:0]      trial;
  logic                 ge;

  assign axis_sel = cmd_i.axis;
  assign s_sel = axis_sel ? sh : sw;
  assign d_sel = axis_sel ? dh : dw;
  assign c_sel = axis_sel ? row_q : col_q;
  assign d_m1  = d_sel - 9'd1;
  assign x_cl  = ({1'b0, c_sel} > d_m1) ? d_m1[COORD_W-1:0] : c_sel;
  assign prod  = PROD_W'({x_cl, 1'b1}) * PROD_W'(s_sel);
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      num_q <= {prod, 7'b0};
      den_q <= d_sel;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? SIZE_W'(trial - {1'b0, den_q}) : trial[SIZE_W-1:0];
      num_q <= {num_q[NUM_W-2:0], ge};
    end
  end

  // quotient to index and Q8 weight
  logic [POS_W-1:0]  pos;
  logic [SIZE_W-1:0] smax, i0_raw, i0_n;
  logic [POS_W-1:0]  w_full;
  logic [WGT_W-1:0]  w_n;

  always_comb begin
    pos    = (num_q < NUM_W'(HALF_Q8)) ? '0 : POS_W'(num_q - NUM_W'(HALF_Q8));
    smax   = s_sel - 9'd2;
    i0_raw = pos[POS_W-1:8];
    w_full = pos - {smax, 8'b0};
    if (i0_raw > smax) begin
      // far edge: weight reaches one or runs past it
      i0_n = smax;
      w_n  = w_full[WGT_W-1:0];
    end else begin
      i0_n = i0_raw;
      w_n  = {3'b0, pos[7:0]};
    end
  end

  logic [SIZE_W-1:0]       x0_q, y0_q;
  logic signed [WGT_W-1:0] wx_q, wy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.post) begin
      if (axis_sel) begin
        y0_q <= i0_n;
        wy_q <= $signed(w_n);
      end else begin
        x0_q <= i0_n;
        wx_q <= $signed(w_n);
      end
    end
  end

  // frame store, single port
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;
  logic [ENTRY_W-1:0] pix_q [4];
  logic [AW-1:0]      waddr, raddr;
  logic [SIZE_W-1:0]  ry, rx;
  logic               mem_we;
  logic [ENTRY_W-1:0] wdata;

  assign mem_we = cmd_i.store && (32'(col_q) < MAX_SRC_W) && (32'(row_q) < MAX_SRC_H);
  assign wdata  = {chan8(v_q[0], bits_q[0]), chan8(v_q[1], bits_q[1]),
                   chan8(v_q[2], bits_q[2])};
  assign waddr  = AW'(row_q) * AW'(MAX_SRC_W) + AW'(col_q);
  assign ry     = y0_q + SIZE_W'(cmd_i.rd_slot[1]);
  assign rx     = x0_q + SIZE_W'(cmd_i.rd_slot[0]);
  assign raddr  = AW'(ry) * AW'(MAX_SRC_W) + AW'(rx);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end else if (cmd_i.rd) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      pix_q[cmd_i.cap_slot] <= rdata_q;
    end
  end

  // filter: horizontal pass, then vertical pass, one channel at a time
  logic signed [WGT_W-1:0] nwx, nwy;
  logic signed [TOP_W-1:0] top_q, bot_q, top_n, bot_n;
  logic signed [ACC_W-1:0] acc;
  logic [23:0]             acc_c, acc_r;
  logic [CHAN_BITS-1:0]    res_q [CHAN_N];

  assign nwx = WGT_W'(ONE_Q8) - wx_q;
  assign nwy = WGT_W'(ONE_Q8) - wy_q;

  always_comb begin
    top_n = TOP_W'($signed({1'b0, pick(pix_q[0], cmd_i.chan)})) * TOP_W'(nwx)
          + TOP_W'($signed({1'b0, pick(pix_q[1], cmd_i.chan)})) * TOP_W'(wx_q);
    bot_n = TOP_W'($signed({1'b0, pick(pix_q[2], cmd_i.chan)})) * TOP_W'(nwx)
          + TOP_W'($signed({1'b0, pick(pix_q[3], cmd_i.chan)})) * TOP_W'(wx_q);
    acc   = ACC_W'(top_q) * ACC_W'(nwy) + ACC_W'(bot_q) * ACC_W'(wy_q);
    if (acc < 0) acc_c = '0;
    else if (acc > ACC_W'(CAP_Q16)) acc_c = 24'(CAP_Q16);
    else acc_c = acc[23:0];
    acc_r = acc_c + 24'(ROUND_Q16);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.h_step) begin
      top_q <= top_n;
      bot_q <= bot_n;
    end
    if (cmd_i.v_step) begin
      res_q[cmd_i.chan] <= acc_r[23:16];
    end
  end

  // output register
  logic             out_valid_q;
  logic [RGB_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {res_q[0][7:3], res_q[1][7:2], res_q[2][7:3]};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_rgb565_o = out_data_q;

  `BSR_ASSERT_IMP(a_no_overwrite, cmd_i.out_load, !out_valid_q || out_ready_i,
                  "result overwritten before taken")
  `BSR_ASSERT_NXT(a_load_shows, cmd_i.out_load, out_valid_q, "loaded result not shown")
  `BSR_ASSERT_IMP(a_port_conflict, cmd_i.rd, !mem_we, "read and write on one port")

endmodule
`default_nettype wire

@@ src/bilinear_scaler_rgb565_core.sv @@
// Bilinear RGB565 scaler: top level joining controller and datapath
// Usage:
//   in_if carries beats of op, pixel_word, col, row. op 0 stores a source
//   pixel: masks cut red, green and blue out of pixel_word, each scaled to
//   8 bits. op 1 asks for the scaled pixel at destination (col, row); one
//   rgb565 beat comes back on out_if. Writes give no beat.
//   One item at a time. A write walks the masks one bit per cycle, down to
//   the lowest mask bit and then along the longest mask run. A read runs
//   two passes of a one-bit-per-cycle divider of 25 steps, four reads of
//   the single-port frame store and two filter steps per channel until its
//   result beat is offered; the next item can be taken once it is offered.
//   Configuration goes through cfg_we_i, cfg_idx_i, cfg_wdata_i; the user
//   must write it only while idle, as the block does not enforce this.
//   Reset restores the register defaults; the frame store is not cleared,
//   so read only neighbours already written.
//   A stalled receiver holds the result in the output register; the next
//   item is still taken and waits for that register only at its end.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_scaler_rgb565_core #(
  parameter int MAX_SRC_W = 256,
  parameter int MAX_SRC_H = 256,
  parameter int MAX_DST_W = 256,
  parameter int MAX_DST_H = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bsr_in_if.sink                         in_if,
  bsr_out_if.source                      out_if,
  input  logic                           cfg_we_i,
  input  logic [bsr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bsr_pkg::WORD_W-1:0]     cfg_wdata_i
);
  import bsr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  bsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bsr_dpath #(
    .MAX_SRC_W (MAX_SRC_W),
    .MAX_SRC_H (MAX_SRC_H),
    .MAX_DST_W (MAX_DST_W),
    .MAX_DST_H (MAX_DST_H)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_op_i         (in_if.op),
    .in_pixel_word_i (in_if.pixel_word),
    .in_col_i        (in_if.col),
    .in_row_i        (in_if.row),
    .out_valid_o     (out_if.valid),
    .out_ready_i     (out_if.ready),
    .out_rgb565_o    (out_if.rgb565)
  );

  assign in_if.ready = in_ready;

endmodule
`default_nettype wire
